FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ZT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ZT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ZT_ASSERT(label, clk, rst, prop)

`define ZT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/ztdc_pkg.sv
// widths, control word types and the microcode table of the divisor count unit
// no dependencies
package ztdc_pkg;

  localparam int N_BITS  = 32;
  localparam int IN_W    = 32;
  localparam int M_W     = N_BITS + 1;
  localparam int I_W     = (M_W + 1) / 2 + 1;
  localparam int SQ_W    = 2 * I_W;
  localparam int CNT_W   = $clog2(M_W + 1);
  localparam int COUNT_W = 12;
  localparam int STEP_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SQUARE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TEST    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIVINIT = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIVSTEP = 3'd4;
  localparam logic [STEP_W-1:0] STEP_TALLY   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_RETURN  = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SQUARE,
    ACT_DIVINIT,
    ACT_DIVSTEP,
    ACT_TALLY,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_IN,
    COND_SQ_GT,
    COND_BIT_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] jmp;
  } ctl_t;

  typedef struct packed {
    logic sq_gt;
    logic bit_more;
    logic out_busy;
  } stat_t;

  function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    unique case (step)
      STEP_IDLE:    w = '{act: ACT_LOAD,    cond: COND_NO_IN,    jmp: STEP_IDLE};
      STEP_SQUARE:  w = '{act: ACT_SQUARE,  cond: COND_NEVER,    jmp: STEP_IDLE};
      STEP_TEST:    w = '{act: ACT_NONE,    cond: COND_SQ_GT,    jmp: STEP_EMIT};
      STEP_DIVINIT: w = '{act: ACT_DIVINIT, cond: COND_NEVER,    jmp: STEP_IDLE};
      STEP_DIVSTEP: w = '{act: ACT_DIVSTEP, cond: COND_BIT_MORE, jmp: STEP_DIVSTEP};
      STEP_TALLY:   w = '{act: ACT_TALLY,   cond: COND_ALWAYS,   jmp: STEP_SQUARE};
      STEP_EMIT:    w = '{act: ACT_EMIT,    cond: COND_OUT_BUSY, jmp: STEP_EMIT};
      STEP_RETURN:  w = '{act: ACT_NONE,    cond: COND_ALWAYS,   jmp: STEP_IDLE};
      default:      w = '{act: ACT_NONE,    cond: COND_ALWAYS,   jmp: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/ztdc_dpath.sv
// datapath of the divisor count unit: trial divisor, square, bit-serial remainder,
// count and output register; depends on ztdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ztdc_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  ztdc_pkg::act_t                 act,
  input  logic                           in_valid,
  input  logic [ztdc_pkg::IN_W-1:0]      n_value,
  output ztdc_pkg::stat_t                stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ztdc_pkg::COUNT_W-1:0]   hit_count,
  output logic                           next_is_composite
);

  logic [ztdc_pkg::M_W-1:0]     m;
  logic [ztdc_pkg::M_W-1:0]     dvd;
  logic [ztdc_pkg::I_W-1:0]     i;
  logic [ztdc_pkg::I_W-1:0]     rem;
  logic [ztdc_pkg::SQ_W-1:0]    sq;
  logic [ztdc_pkg::CNT_W-1:0]   cnt;
  logic [ztdc_pkg::COUNT_W-1:0] count;

  logic [ztdc_pkg::I_W:0]       trial;
  logic [ztdc_pkg::I_W-1:0]     rem_next;
  logic [ztdc_pkg::COUNT_W:0]   sum;
  logic [ztdc_pkg::COUNT_W-1:0] count_next;
  logic                         emit;

  // one restoring division step
  always_comb begin
    trial = {rem, dvd[ztdc_pkg::M_W-1]};
    if (trial >= {1'b0, i}) begin
      rem_next = ztdc_pkg::I_W'(trial - {1'b0, i});
    end else begin
      rem_next = trial[ztdc_pkg::I_W-1:0];
    end
  end

  // a divisor pair, or a single divisor at the square root
  always_comb begin
    if (sq == ztdc_pkg::SQ_W'(m)) begin
      sum = {1'b0, count} + (ztdc_pkg::COUNT_W+1)'(1);
    end else begin
      sum = {1'b0, count} + (ztdc_pkg::COUNT_W+1)'(2);
    end
    if (rem != '0) begin
      count_next = count;
    end else if (sum[ztdc_pkg::COUNT_W]) begin
      count_next = ztdc_pkg::COUNT_MAX;
    end else begin
      count_next = sum[ztdc_pkg::COUNT_W-1:0];
    end
  end

  assign stat.sq_gt    = sq > ztdc_pkg::SQ_W'(m);
  assign stat.bit_more = cnt != ztdc_pkg::CNT_W'(1);
  assign stat.out_busy = out_valid && !out_ready;
  assign emit          = (act == ztdc_pkg::ACT_EMIT) && !stat.out_busy;

  always_ff @(posedge clk) begin
    unique case (act)
      ztdc_pkg::ACT_LOAD: begin
        if (in_valid) begin
          m     <= ztdc_pkg::M_W'(n_value[ztdc_pkg::N_BITS-1:0]) + ztdc_pkg::M_W'(1);
          i     <= ztdc_pkg::I_W'(2);
          count <= '0;
        end
      end
      ztdc_pkg::ACT_SQUARE: begin
        sq <= ztdc_pkg::SQ_W'(i) * ztdc_pkg::SQ_W'(i);
      end
      ztdc_pkg::ACT_DIVINIT: begin
        dvd <= m;
        rem <= '0;
        cnt <= ztdc_pkg::CNT_W'(ztdc_pkg::M_W);
      end
      ztdc_pkg::ACT_DIVSTEP: begin
        dvd <= {dvd[ztdc_pkg::M_W-2:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt - ztdc_pkg::CNT_W'(1);
      end
      ztdc_pkg::ACT_TALLY: begin
        count <= count_next;
        i     <= i + ztdc_pkg::I_W'(1);
      end
      ztdc_pkg::ACT_EMIT,
      ztdc_pkg::ACT_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit_count         <= count;
      next_is_composite <= count != '0;
    end
  end

  `ZT_ASSERT(a_flag_matches_count, clk, rst,
             !out_valid || (next_is_composite == (hit_count != '0)))
  `ZT_ASSERT_NEXT(a_rem_below_divisor, clk, rst, act == ztdc_pkg::ACT_DIVSTEP, rem < i)

endmodule

FILE: sv/zone_two_divisor_count_unit.sv
// Counts the divisors of n_value+1 other than 1 and itself (saturating at 4095) and
// flags n_value+1 as composite when that count is nonzero; 0 for n_value below 3.
// One request at a time. Each trial divisor i = 2, 3, ... while i*i <= n_value+1 goes
// through square, bound test, divider setup, 33 remainder steps of the single
// bit-serial restoring divider, and tally; the result register frees in_ready before
// the result is taken.
// depends on ztdc_pkg, ztdc_dpath and assert_macros.svh
`include "assert_macros.svh"

module zone_two_divisor_count_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ztdc_pkg::IN_W-1:0]     n_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ztdc_pkg::COUNT_W-1:0]  hit_count,
  output logic                          next_is_composite
);

  logic [ztdc_pkg::STEP_W-1:0] step;
  logic [ztdc_pkg::STEP_W-1:0] step_next;
  ztdc_pkg::ctl_t              ctl;
  ztdc_pkg::stat_t             stat;
  logic                        take;

  assign ctl      = ztdc_pkg::ctl_rom(step);
  assign in_ready = ctl.act == ztdc_pkg::ACT_LOAD;

  always_comb begin
    unique case (ctl.cond)
      ztdc_pkg::COND_ALWAYS:   take = 1'b1;
      ztdc_pkg::COND_NEVER:    take = 1'b0;
      ztdc_pkg::COND_NO_IN:    take = !in_valid;
      ztdc_pkg::COND_SQ_GT:    take = stat.sq_gt;
      ztdc_pkg::COND_BIT_MORE: take = stat.bit_more;
      ztdc_pkg::COND_OUT_BUSY: take = stat.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  assign step_next = take ? ctl.jmp : step + ztdc_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ztdc_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  ztdc_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .act               (ctl.act),
    .in_valid          (in_valid),
    .n_value           (n_value),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hit_count         (hit_count),
    .next_is_composite (next_is_composite)
  );

  `ZT_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_valid && in_ready,
                  step == ztdc_pkg::STEP_SQUARE)
  `ZT_ASSERT_NEXT(a_division_ends_in_tally, clk, rst,
                  step == ztdc_pkg::STEP_DIVSTEP && !stat.bit_more,
                  step == ztdc_pkg::STEP_TALLY)

endmodule
